@@ hdl/hrst_pkg.sv @@
// Shared types and constants for the hash ring successor table.
// Holds beat payload structs, operation and status codes, cell control struct.
// No dependencies.
`default_nettype none

package hrst_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int ID_BITS_DEF   = 16;
    localparam int KEY_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int COUNT_OUT_W   = 7;

    localparam logic [KEY_W-1:0] ID_LIMIT_RESET = 16'hFFFF;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]       successor_id;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] node_count_out;
    } rsp_item_t;

    // commit strobes sent to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

@@ hdl/hrst_cell.sv @@
// One slot of the sorted identifier chain.
// Compares its entry against the key and shifts with its neighbors on commit.
// Depends on hrst_pkg.
`default_nettype none

module hrst_cell #(
    parameter int ID_BITS = hrst_pkg::ID_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ID_BITS-1:0]  key,
    input  wire hrst_pkg::cell_ctl_t ctl,
    input  wire logic [ID_BITS-1:0]  left_id,
    input  wire logic                left_valid,
    input  wire logic                left_ge,
    input  wire logic [ID_BITS-1:0]  right_id,
    input  wire logic                right_valid,
    output logic [ID_BITS-1:0]       id,
    output logic                     valid,
    output logic                     ge,
    output logic                     eq,
    output logic                     sel
);

    logic [ID_BITS-1:0] id_reg, id_next;
    logic               valid_reg, valid_next;
    logic               after, left_after;

    assign id    = id_reg;
    assign valid = valid_reg;
    assign ge    = valid_reg && (id_reg >= key);
    assign eq    = valid_reg && (id_reg == key);
    // first held entry at or above the key
    assign sel   = ge && !left_ge;

    // slot sits at or past the insert / remove position
    assign after      = ge || !valid_reg;
    assign left_after = left_ge || !left_valid;

    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        if (ctl.ins && after)
        begin
            id_next    = left_after ? left_id : key;
            valid_next = valid_reg || left_valid;
        end
        else if (ctl.rem && after)
        begin
            id_next    = right_id;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

`default_nettype wire

@@ hdl/hrst_chain.sv @@
// Row of hrst_cell slots holding the sorted identifiers.
// Reduces per-slot match flags and the selected successor for the controller.
// Depends on hrst_pkg and hrst_cell.
`default_nettype none

module hrst_chain #(
    parameter int MAX_NODES = hrst_pkg::MAX_NODES_DEF,
    parameter int ID_BITS   = hrst_pkg::ID_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ID_BITS-1:0]  key,
    input  wire hrst_pkg::cell_ctl_t ctl,
    output logic                     any_eq,
    output logic                     any_sel,
    output logic [ID_BITS-1:0]       sel_id,
    output logic [ID_BITS-1:0]       first_id
);

    logic [ID_BITS-1:0] ids   [MAX_NODES];
    logic               valids[MAX_NODES];
    logic               ges   [MAX_NODES];
    logic               eqs   [MAX_NODES];
    logic               sels  [MAX_NODES];

    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_cell
        logic [ID_BITS-1:0] l_id, r_id;
        logic               l_valid, l_ge, r_valid;

        if (i == 0)
        begin : g_head
            assign l_id    = key;
            assign l_valid = 1'b1;
            assign l_ge    = 1'b0;
        end
        else
        begin : g_body
            assign l_id    = ids[i-1];
            assign l_valid = valids[i-1];
            assign l_ge    = ges[i-1];
        end

        if (i == MAX_NODES - 1)
        begin : g_tail
            assign r_id    = ids[i];
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid
            assign r_id    = ids[i+1];
            assign r_valid = valids[i+1];
        end

        hrst_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (key),
            .ctl        (ctl),
            .left_id    (l_id),
            .left_valid (l_valid),
            .left_ge    (l_ge),
            .right_id   (r_id),
            .right_valid(r_valid),
            .id         (ids[i]),
            .valid      (valids[i]),
            .ge         (ges[i]),
            .eq         (eqs[i]),
            .sel        (sels[i])
        );
    end

    assign first_id = ids[0];

    // at most one slot selects, so an and-or tree picks its entry
    always_comb
    begin
        any_eq  = 1'b0;
        any_sel = 1'b0;
        sel_id  = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            any_eq  = any_eq || eqs[i];
            any_sel = any_sel || sels[i];
            sel_id  = sel_id | (ids[i] & {ID_BITS{sels[i]}});
        end
    end

endmodule

`default_nettype wire

@@ hdl/hash_ring_successor_table_top.sv @@
// Hash ring successor table, top level: request/response control and id limit register.
// Requests are latched when accepted; the commit step then loads the response register.
// The block takes no new request until the current one has committed.
// A full response register holds the commit step until the beat is taken.
// Reset clears the node count and all slot valid bits and sets id_limit to 65535.
// Depends on hrst_pkg and hrst_chain.
`default_nettype none

module hash_ring_successor_table_top #(
    parameter int MAX_NODES = hrst_pkg::MAX_NODES_DEF,
    parameter int ID_BITS   = hrst_pkg::ID_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire hrst_pkg::req_item_t        req_data,
    // response channel
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output hrst_pkg::rsp_item_t             rsp_data,
    // configuration channel: id_limit
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [hrst_pkg::KEY_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (ID_BITS > hrst_pkg::KEY_W) ? ID_BITS : hrst_pkg::KEY_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_NODES);

    hrst_pkg::state_t state_reg, state_next;

    // latched request
    logic [1:0]         kind_reg;
    logic [ID_BITS-1:0] key_reg;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [hrst_pkg::KEY_W-1:0]    id_limit_reg;
    logic                          rsp_valid_reg;
    hrst_pkg::rsp_item_t           rsp_reg, rsp_next;

    logic                req_fire;
    logic                exec;
    logic                commit;
    hrst_pkg::cell_ctl_t ctl;

    logic               any_eq, any_sel;
    logic [ID_BITS-1:0] sel_id, first_id;
    logic [ID_BITS-1:0] succ;
    logic               over_limit, full;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign req_fire  = req_valid && req_ready;

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrst_pkg::ST_IDLE:
                if (req_fire)
                    state_next = hrst_pkg::ST_EXEC;
            hrst_pkg::ST_EXEC:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = hrst_pkg::ST_IDLE;
            default:
                state_next = hrst_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        exec      = 1'b0;
        unique case (state_reg)
            hrst_pkg::ST_IDLE:
                req_ready = 1'b1;
            hrst_pkg::ST_EXEC:
                exec = 1'b1;
            default:
                req_ready = 1'b0;
        endcase
    end

    // commit only when the response register has room
    assign commit = exec && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hrst_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- request latch ----------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req_data.kind;
            // keep only the ring's identifier bits
            key_reg  <= ID_BITS'(req_data.key);
        end
    end

    // ---------------- id limit register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            id_limit_reg <= hrst_pkg::ID_LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            id_limit_reg <= cfg_data;
    end

    // ---------------- slot chain ----------------
    hrst_chain #(
        .MAX_NODES(MAX_NODES),
        .ID_BITS  (ID_BITS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key_reg),
        .ctl     (ctl),
        .any_eq  (any_eq),
        .any_sel (any_sel),
        .sel_id  (sel_id),
        .first_id(first_id)
    );

    assign over_limit = CMP_W'(key_reg) > CMP_W'(id_limit_reg);
    assign full       = (count_reg == CNT_FULL);
    // wrap to the lowest identifier when no entry is at or above the key
    assign succ       = any_sel ? sel_id : first_id;

    // ---------------- operation decode ----------------
    always_comb
    begin
        ctl                     = '0;
        count_next              = count_reg;
        rsp_next.successor_id   = '0;
        rsp_next.status         = hrst_pkg::STATUS_OK;
        unique case (kind_reg)
            hrst_pkg::KIND_LOOKUP:
            begin
                if (count_reg == '0)
                    rsp_next.status = hrst_pkg::STATUS_EMPTY;
                else
                    rsp_next.successor_id = hrst_pkg::KEY_W'(succ);
            end
            hrst_pkg::KIND_ADD:
            begin
                priority if (any_eq)
                    rsp_next.status = hrst_pkg::STATUS_DUP;
                else if (over_limit || full)
                    rsp_next.status = hrst_pkg::STATUS_FULL_RANGE;
                else
                begin
                    ctl.ins    = commit;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            hrst_pkg::KIND_REMOVE:
            begin
                if (any_eq)
                begin
                    ctl.rem    = commit;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                    rsp_next.status = hrst_pkg::STATUS_MISSING;
            end
            default:
                rsp_next.status = hrst_pkg::STATUS_OK;
        endcase
        rsp_next.node_count_out = hrst_pkg::COUNT_OUT_W'(count_next);
    end

    // ---------------- node count and response register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for hash_ring_successor_table_top: directed and random
// lookup/add/remove beats checked against an in-bench model of the sorted ring.
// Depends on hrst_pkg and the RTL of hash_ring_successor_table_top.
`timescale 1ns / 1ps

module testbench;

    localparam int RING_SLOTS     = hrst_pkg::MAX_NODES_DEF;
    // the kind field has one code the block leaves unused
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // bias of the random kind mix
    localparam int BIAS_GROW      = 0;
    localparam int BIAS_SHRINK    = 1;
    localparam int BIAS_BALANCED  = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MIX_PHASES     = 11;
    localparam int MIX_BEATS      = 150;
    localparam int REPORT_MAX     = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_ready;
    hrst_pkg::req_item_t        req_data;
    logic                       rsp_valid;
    logic                       rsp_ready;
    hrst_pkg::rsp_item_t        rsp_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [hrst_pkg::KEY_W-1:0] cfg_data;

    // Ring model: ascending identifiers, entry count and the add limit.
    logic [hrst_pkg::KEY_W-1:0] ring_ids [RING_SLOTS];
    int                         ring_count;
    logic [hrst_pkg::KEY_W-1:0] ring_limit;

    // Responses still owed by the block, oldest first.
    hrst_pkg::rsp_item_t        owed_rsp_q [$];

    int               mismatch_count;
    int               idle_cycles;
    bit               hold_req;
    int               burst_left;

    hash_ring_successor_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one request to the ring model and return the response it owes.
    function automatic hrst_pkg::rsp_item_t ring_apply(input hrst_pkg::req_item_t r);
        hrst_pkg::rsp_item_t res;
        int        pos;
        int        i;
        bit        hit;
        res = '0;
        res.status = hrst_pkg::STATUS_OK;
        // first entry at or above the key, ring_count when none
        pos = ring_count;
        for (i = ring_count - 1; i >= 0; i--)
            if (ring_ids[i] >= r.key)
                pos = i;
        hit = (pos < ring_count) && (ring_ids[pos] == r.key);
        case (r.kind)
            hrst_pkg::KIND_LOOKUP:
            begin
                if (ring_count == 0)
                    res.status = hrst_pkg::STATUS_EMPTY;
                else if (pos < ring_count)
                    res.successor_id = ring_ids[pos];
                else
                    res.successor_id = ring_ids[0];   // wrap past the top of the ring
            end
            hrst_pkg::KIND_ADD:
            begin
                // duplicate wins over range and full checks
                if (hit)
                    res.status = hrst_pkg::STATUS_DUP;
                else if (r.key > ring_limit || ring_count >= RING_SLOTS)
                    res.status = hrst_pkg::STATUS_FULL_RANGE;
                else
                begin
                    for (i = ring_count; i > pos; i--)
                        ring_ids[i] = ring_ids[i-1];
                    ring_ids[pos] = r.key;
                    ring_count++;
                end
            end
            hrst_pkg::KIND_REMOVE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < ring_count; i++)
                        ring_ids[i] = ring_ids[i+1];
                    ring_count--;
                end
                else
                    res.status = hrst_pkg::STATUS_MISSING;
            end
            default: ;   // spare kind: no change, zero successor and OK status
        endcase
        res.node_count_out = hrst_pkg::COUNT_OUT_W'(ring_count);
        return res;
    endfunction

    // Draw a key: held ids and their neighbors, edges, small values and noise.
    function automatic logic [hrst_pkg::KEY_W-1:0] pick_key();
        int                         sel;
        logic [hrst_pkg::KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        k   = hrst_pkg::KEY_W'($urandom);
        if (ring_count > 0 && sel <= 2)
            k = ring_ids[$urandom_range(0, ring_count - 1)];
        else if (ring_count > 0 && sel == 3)
            k = ring_ids[$urandom_range(0, ring_count - 1)]
                + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
        else if (sel == 4)
            k = $urandom_range(0, 1) ? '1 : '0;
        else if (sel == 5)
            k = hrst_pkg::KEY_W'($urandom_range(0, 63));
        return k;
    endfunction

    function automatic logic [1:0] pick_kind(input int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            BIAS_GROW:
                return (r < 55) ? hrst_pkg::KIND_ADD :
                       (r < 80) ? hrst_pkg::KIND_LOOKUP :
                       (r < 95) ? hrst_pkg::KIND_REMOVE : KIND_SPARE;
            BIAS_SHRINK:
                return (r < 15) ? hrst_pkg::KIND_ADD :
                       (r < 40) ? hrst_pkg::KIND_LOOKUP :
                       (r < 95) ? hrst_pkg::KIND_REMOVE : KIND_SPARE;
            default:
                return (r < 22) ? hrst_pkg::KIND_ADD :
                       (r < 72) ? hrst_pkg::KIND_LOOKUP :
                       (r < 95) ? hrst_pkg::KIND_REMOVE : KIND_SPARE;
        endcase
    endfunction

    // Response checker and request tracker, both sampled at the rising edge.
    always @(posedge clk)
    begin : scoreboard
        hrst_pkg::rsp_item_t owed;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: response beat with nothing owed: ", $realtime,
                                 "succ=%h st=%0d cnt=%0d", rsp_data.successor_id,
                                 rsp_data.status, rsp_data.node_count_out);
                end
                else
                begin
                    owed = owed_rsp_q.pop_front();
                    if (rsp_data.successor_id !== owed.successor_id ||
                        rsp_data.status !== owed.status ||
                        rsp_data.node_count_out !== owed.node_count_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: mismatch: expected ", $realtime,
                                     "succ=%h st=%0d cnt=%0d, ", owed.successor_id,
                                     owed.status, owed.node_count_out,
                                     "got succ=%h st=%0d cnt=%0d", rsp_data.successor_id,
                                     rsp_data.status, rsp_data.node_count_out);
                    end
                end
            end
            // pop before push: a request never answers in its own cycle
            if (req_valid && req_ready)
                owed_rsp_q.push_back(ring_apply(req_data));
            if (cfg_valid && cfg_ready)
                ring_limit = cfg_data;
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long.
    always @(posedge clk)
    begin : watchdog
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: stall on a pattern whose mode is redrawn at random,
    // and hold off for a long stretch whenever the stimulus asks for it.
    initial
    begin : rsp_ready_driver
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        rsp_ready = 1'b0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                phase = (phase + 1) % 7;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 4) != 0);
                    default: rsp_ready <= (phase >= 3);
                endcase
            end
        end
    end

    // Offer one request beat and hold it until accepted; return at a falling edge.
    task automatic send_item(input logic [1:0] kind, input logic [hrst_pkg::KEY_W-1:0] key);
        hrst_pkg::req_item_t item;
        item.kind = kind;
        item.key  = key;
        req_data  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Send in bursts: drop valid for a random gap once the burst runs out.
    task automatic send_paced(input logic [1:0] kind, input logic [hrst_pkg::KEY_W-1:0] key);
        send_item(kind, key);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold the sender until every owed response has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (owed_rsp_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Write id_limit with the block idle.
    task automatic write_id_limit(input logic [hrst_pkg::KEY_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Empty ring: lookup flags empty, remove reports missing, spare kind is a no-op.
    task automatic test_empty_ring();
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0000);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'hFFFF);
        send_paced(hrst_pkg::KIND_REMOVE, 16'h1234);
        send_paced(KIND_SPARE, 16'hFFFF);
    endtask

    // Exact hits, successors, wrap below the first and above the last id,
    // duplicate add and absent remove.
    task automatic test_basic_ops();
        send_paced(hrst_pkg::KIND_ADD, 16'h0064);
        send_paced(hrst_pkg::KIND_ADD, 16'h1388);
        send_paced(hrst_pkg::KIND_ADD, 16'hFFFF);
        send_paced(hrst_pkg::KIND_ADD, 16'h0000);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0000);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0001);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h1388);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h1389);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'hFFFF);
        send_paced(hrst_pkg::KIND_REMOVE, 16'h0000);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0000);
        send_paced(hrst_pkg::KIND_REMOVE, 16'hFFFF);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h1770);
        send_paced(hrst_pkg::KIND_ADD, 16'h1388);
        send_paced(hrst_pkg::KIND_REMOVE, 16'h004D);
        send_paced(KIND_SPARE, 16'h5A5A);
    endtask

    // Adds just above and at the limit, with the limit at its low extreme too.
    task automatic test_id_limit();
        write_id_limit(16'h00FF);
        send_paced(hrst_pkg::KIND_ADD, 16'h0100);
        send_paced(hrst_pkg::KIND_ADD, 16'h00FF);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0100);
        write_id_limit(16'h0000);
        send_paced(hrst_pkg::KIND_ADD, 16'h0001);
        send_paced(hrst_pkg::KIND_ADD, 16'h0000);
        write_id_limit(16'hFFFF);
        send_paced(hrst_pkg::KIND_ADD, 16'hFFFF);
    endtask

    // Fill the ring, then check that a duplicate still wins over full.
    task automatic test_full_ring();
        while (ring_count < RING_SLOTS)
        begin
            repeat (RING_SLOTS - ring_count)
                send_paced(hrst_pkg::KIND_ADD, hrst_pkg::KEY_W'($urandom));
            wait_drained();
        end
        send_paced(hrst_pkg::KIND_ADD, ring_ids[$urandom_range(0, RING_SLOTS - 1)]);
        send_paced(hrst_pkg::KIND_ADD, hrst_pkg::KEY_W'($urandom));
        send_paced(hrst_pkg::KIND_ADD, ring_ids[0]);
        repeat (6)
            send_paced(hrst_pkg::KIND_LOOKUP, pick_key());
        send_paced(hrst_pkg::KIND_LOOKUP, 16'hFFFF);
        send_paced(hrst_pkg::KIND_LOOKUP, 16'h0000);
    endtask

    // Long receiver hold-off with the sender offering back to back,
    // so the block fills and stalls its input; then pause until drained.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40)
            send_item(pick_kind(BIAS_BALANCED), pick_key());
        wait_drained();
    endtask

    // Random phases, each writing an id_limit and picking a kind bias.
    task automatic test_random_mix();
        int                         phase;
        logic [hrst_pkg::KEY_W-1:0] lim;
        for (phase = 0; phase < MIX_PHASES; phase++)
        begin
            case (phase % 4)
                0:       lim = 16'hFFFF;
                1:       lim = hrst_pkg::KEY_W'($urandom_range(1, 16'hFFFE));
                2:       lim = (phase == 2) ? 16'h0000 : 16'h7FFF;
                default: lim = hrst_pkg::KEY_W'($urandom_range(16'hF000, 16'hFFFF));
            endcase
            write_id_limit(lim);
            repeat (MIX_BEATS)
                send_paced(pick_kind(phase % 3), pick_key());
        end
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_req       = 1'b0;
        burst_left     = 0;
        ring_count     = 0;
        ring_limit     = hrst_pkg::ID_LIMIT_RESET;
        // hold reset low, then release it once
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_ring();
        test_basic_ops();
        test_id_limit();
        test_full_ring();
        test_backpressure();
        test_random_mix();

        // drain, then let the pipeline settle to catch stray beats
        wait_drained();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0 && owed_rsp_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
